FILE: design/cbts_pkg.sv
package cbts_pkg;

    // Word widths on the stream ports
    localparam int CLK_W       = 32;
    localparam int BAUD_W      = 20;
    localparam int IN_TDATA_W  = 56;
    localparam int DIV_W       = 4;
    localparam int TWORD_W     = 15;
    localparam int OUT_TDATA_W = 24;

    // Search counters
    localparam int QUANTA_W = 6;
    localparam int SEGS_W   = 5;
    localparam int STEP_W   = 10;   // (div + 1) * quanta, at most 512
    localparam int PROD_W   = 14;   // (div + 1) * quanta * segs, at most 8704
    localparam int CNT_W    = $clog2(CLK_W);

    localparam logic [DIV_W-1:0]    DIV_LAST    = 4'd15;
    localparam logic [QUANTA_W-1:0] QUANTA_LAST = 6'd32;
    localparam logic [SEGS_W-1:0]   SEGS_FIRST  = 5'd3;
    localparam logic [SEGS_W-1:0]   SEGS_LAST   = 5'd17;
    localparam logic [3:0]          SJW_MAX     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_OUT
    } state_t;

    // Outcome of one search pass
    typedef struct packed {
        logic                found;
        logic [DIV_W-1:0]    div;
        logic [QUANTA_W-1:0] quanta;
        logic [SEGS_W-1:0]   segs;
    } search_res_t;

    // Pack quanta and total segments into the bit timing word
    function automatic logic [TWORD_W-1:0] pack_timing(
        input logic [QUANTA_W-1:0] quanta,
        input logic [SEGS_W-1:0]   segs
    );
        logic [SEGS_W-1:0]   rest;
        logic [3:0]          seg1;
        logic [3:0]          seg2;
        logic [1:0]          sjw;
        logic [QUANTA_W-1:0] qm1;
        rest = segs - SEGS_FIRST;
        seg1 = rest[4:1];
        seg2 = rest[3:0] - seg1;
        sjw  = (seg1 > SJW_MAX) ? SJW_MAX[1:0] : seg1[1:0];
        qm1  = quanta - 6'd1;
        return {seg2[2:0], seg1, sjw, qm1};
    endfunction

endpackage

FILE: design/cbts_divider.sv
module cbts_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cbts_pkg::CLK_W-1:0]    dividend,
    input  logic [cbts_pkg::BAUD_W-1:0]   divisor,
    output logic                          done,
    output logic [cbts_pkg::CLK_W-1:0]    quotient
);
    import cbts_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [BAUD_W-1:0] rem_reg, rem_next;
    logic [BAUD_W-1:0] dvs_reg, dvs_next;

    logic [BAUD_W:0]   rem_sh;
    logic [BAUD_W:0]   diff;
    logic              ge;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign rem_sh = {rem_reg, quo_reg[CLK_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
            quo_next   = {quo_reg[CLK_W-2:0], ge};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(CLK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/cbts_search.sv
module cbts_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cbts_pkg::CLK_W-1:0]  target,
    output logic                        done,
    output cbts_pkg::search_res_t       res
);
    import cbts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [QUANTA_W-1:0] quanta_reg, quanta_next;
    logic [SEGS_W-1:0]   segs_reg, segs_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                hit;
    logic                last;
    logic [STEP_W-1:0]   step_q;
    logic [STEP_W-1:0]   step_d;
    logic [STEP_W-1:0]   step_new;
    logic [PROD_W-1:0]   prod_first;

    // Running product is kept equal to (div + 1) * quanta * segs
    assign hit  = (target == {{(CLK_W-PROD_W){1'b0}}, prod_reg});
    assign last = (div_reg == DIV_LAST) && (quanta_reg == QUANTA_LAST)
                  && (segs_reg == SEGS_LAST);

    assign step_q     = step_reg + {{(STEP_W-DIV_W-1){1'b0}}, 1'b0, div_reg} + 1'b1;
    assign step_d     = {{(STEP_W-DIV_W-1){1'b0}}, 1'b0, div_reg} + 2'd2;
    assign step_new   = (quanta_reg != QUANTA_LAST) ? step_q : step_d;
    assign prod_first = {{(PROD_W-STEP_W){1'b0}}, step_new}
                        + {{(PROD_W-STEP_W-1){1'b0}}, step_new, 1'b0};

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        div_next    = div_reg;
        quanta_next = quanta_reg;
        segs_next   = segs_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            found_next  = 1'b0;
            div_next    = '0;
            quanta_next = QUANTA_W'(1);
            segs_next   = SEGS_FIRST;
            step_next   = STEP_W'(1);
            prod_next   = PROD_W'(SEGS_FIRST);
        end
        else if (busy_reg)
        begin
            if (hit || last)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = hit;
            end
            else if (segs_reg != SEGS_LAST)
            begin
                segs_next = segs_reg + 1'b1;
                prod_next = prod_reg + {{(PROD_W-STEP_W){1'b0}}, step_reg};
            end
            else
            begin
                // Wrap segments; advance quanta, or the divider on its last quanta
                segs_next = SEGS_FIRST;
                step_next = step_new;
                prod_next = prod_first;
                if (quanta_reg != QUANTA_LAST)
                begin
                    quanta_next = quanta_reg + 1'b1;
                end
                else
                begin
                    quanta_next = QUANTA_W'(1);
                    div_next    = div_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            div_reg    <= '0;
            quanta_reg <= QUANTA_W'(1);
            segs_reg   <= SEGS_FIRST;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            div_reg    <= div_next;
            quanta_reg <= quanta_next;
            segs_reg   <= segs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        prod_reg <= prod_next;
    end

    assign done       = done_reg;
    assign res.found  = found_reg;
    assign res.div    = div_reg;
    assign res.quanta = quanta_reg;
    assign res.segs   = segs_reg;

endmodule

FILE: design/can_bit_timing_search_top.sv
// A zero bit rate gives a waiting result in the cycle after the word is accepted;
//   otherwise the word passes through the division and then the search.
// Throughput: one word at a time; the next word is taken once the result is taken.
//   The search unit tries one (divider, quanta, segments) combination per cycle.
// Reset: rst_n is asynchronous, active low; the block comes up idle and ready.
module can_bit_timing_search_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: [31:0] clock_hz, [51:32] baud_hz, [55:52] zero
    input  logic [cbts_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: [3:0] prescale_div, [18:4] timing_word, [23:19] zero
    output logic [cbts_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // m_tuser: [0] found
    output logic                              m_tuser
);
    import cbts_pkg::*;

    state_t             state_reg, state_next;

    logic [CLK_W-1:0]   clock_hz;
    logic [BAUD_W-1:0]  baud_hz;
    logic               baud_zero;

    logic               div_start;
    logic               div_done;
    logic [CLK_W-1:0]   quotient;
    logic               srch_start;
    logic               srch_done;
    search_res_t        srch_res;

    logic               load_hit;
    logic               load_zero;
    logic               found_reg;
    logic [DIV_W-1:0]   pdiv_reg;
    logic [TWORD_W-1:0] tword_reg;

    assign clock_hz  = s_tdata[CLK_W-1:0];
    assign baud_hz   = s_tdata[CLK_W+BAUD_W-1:CLK_W];
    assign baud_zero = (baud_hz == '0);

    // Clocks per bit, one quotient bit per cycle
    cbts_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_hz),
        .divisor  (baud_hz),
        .done     (div_done),
        .quotient (quotient)
    );

    // Ordered search over divider, quanta and segments
    cbts_search u_srch (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (srch_start),
        .target (quotient),
        .done   (srch_done),
        .res    (srch_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = baud_zero ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        div_start  = 1'b0;
        srch_start = 1'b0;
        load_hit   = 1'b0;
        load_zero  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && !baud_zero;
                load_zero = s_tvalid && baud_zero;
            end
            ST_DIV:
            begin
                srch_start = div_done;
            end
            ST_SEARCH:
            begin
                load_hit = srch_done;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_zero)
            begin
                found_reg <= 1'b0;
            end
            else if (load_hit)
            begin
                found_reg <= srch_res.found;
            end
        end
    end

    // Hold the result word; a miss or a zero bit rate gives zero fields
    always_ff @(posedge clk)
    begin
        if (load_zero || (load_hit && !srch_res.found))
        begin
            pdiv_reg  <= '0;
            tword_reg <= '0;
        end
        else if (load_hit)
        begin
            pdiv_reg  <= srch_res.div;
            tword_reg <= pack_timing(srch_res.quanta, srch_res.segs);
        end
    end

    assign m_tdata = {{(OUT_TDATA_W-DIV_W-TWORD_W){1'b0}}, tword_reg, pdiv_reg};
    assign m_tuser = found_reg;

endmodule

FILE: design/cbts_checker.sv
module cbts_port_checks (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cbts_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser
);
    import cbts_pkg::*;

    // One word in flight: never ready while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Drop ready once a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after an accepted word");

    // A miss carries zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-zero fields on a miss");

    // seg2 equals seg1 or seg1 + 1 on a hit
    a_seg_split: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (({1'b0, m_tdata[18:16]} == m_tdata[15:12])
             || ({1'b0, m_tdata[18:16]} == (m_tdata[15:12] + 4'd1))))
        else $error("segment split out of range");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind can_bit_timing_search_top cbts_port_checks u_cbts_checker (.*);

FILE: bench/cbts_checker.sv
module cbts_checker
    import cbts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               found;
        logic [DIV_W-1:0]   div;
        logic [TWORD_W-1:0] word;
    } timing_t;

    timing_t timing_q[$];

    // Mirror of the search state: last quotient and where the last search stopped
    logic [CLK_W-1:0]    quotient;
    logic [DIV_W-1:0]    stop_div;
    logic [QUANTA_W-1:0] stop_quanta;
    logic [SEGS_W-1:0]   stop_segs;

    function automatic timing_t find_timing(
        input logic [CLK_W-1:0]  clock_hz,
        input logic [BAUD_W-1:0] baud_hz
    );
        timing_t     t;
        int unsigned rest;
        logic [3:0]  seg1;
        logic [3:0]  seg2;
        logic [1:0]  sjw;
        logic [5:0]  qm1;
        t = '0;
        if (baud_hz == '0)
        begin
            quotient = '0;
            return t;
        end
        quotient = clock_hz / baud_hz;
        for (int unsigned d = 0; d <= DIV_LAST; d++)
        begin
            for (int unsigned q = 1; q <= QUANTA_LAST; q++)
            begin
                for (int unsigned s = SEGS_FIRST; s <= SEGS_LAST; s++)
                begin
                    if (quotient == s * q * (d + 1))
                    begin
                        rest        = s - SEGS_FIRST;
                        seg1        = 4'(rest / 2);
                        seg2        = 4'(rest - seg1);
                        sjw         = (seg1 > SJW_MAX) ? 2'd3 : seg1[1:0];
                        qm1         = 6'(q - 1);
                        stop_div    = DIV_W'(d);
                        stop_quanta = QUANTA_W'(q);
                        stop_segs   = SEGS_W'(s);
                        t.found     = 1'b1;
                        t.div       = DIV_W'(d);
                        t.word      = {seg2[2:0], seg1, sjw, qm1};
                        return t;
                    end
                end
            end
        end
        stop_div    = DIV_LAST;
        stop_quanta = QUANTA_LAST;
        stop_segs   = SEGS_LAST;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        timing_t want;
        if (!rst_n)
        begin
            timing_q.delete();
            quotient    = '0;
            stop_div    = '0;
            stop_quanta = 6'd1;
            stop_segs   = SEGS_FIRST;
        end
        else
        begin
            if (s_tvalid && s_tready)
                timing_q.push_back(find_timing(s_tdata[CLK_W-1:0],
                                               s_tdata[CLK_W+BAUD_W-1:CLK_W]));
            if (m_tvalid && m_tready)
            begin
                if (timing_q.size() == 0)
                    report_mismatch("unexpected result", 32'd0, {m_tdata, 7'd0, m_tuser});
                else
                begin
                    want = timing_q.pop_front();
                    if (m_tuser !== want.found)
                        report_mismatch("found", 32'(want.found), 32'(m_tuser));
                    if (m_tdata[DIV_W-1:0] !== want.div)
                        report_mismatch("prescale_div", 32'(want.div),
                                        32'(m_tdata[DIV_W-1:0]));
                    if (m_tdata[DIV_W+TWORD_W-1:DIV_W] !== want.word)
                        report_mismatch("timing_word", 32'(want.word),
                                        32'(m_tdata[DIV_W+TWORD_W-1:DIV_W]));
                    if (m_tdata[OUT_TDATA_W-1:DIV_W+TWORD_W] !== '0)
                        report_mismatch("tdata padding", 32'd0,
                                        32'(m_tdata[OUT_TDATA_W-1:DIV_W+TWORD_W]));
                end
            end
        end
        pending = timing_q.size();
    end

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbts_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 76;
    // Allow for a full search with no match and for the long receiver
    // hold-off on top of that, several times over.
    localparam int QUIET_LIMIT  = 40000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 50;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: [31:0] clock_hz, [51:32] baud_hz, [55:52] zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: [3:0] prescale_div, [18:4] timing_word, [23:19] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    // m_tuser: [0] found
    logic                   m_tuser;

    int   errors;
    int   pending;
    int   idle_pct   = 0;    // chance that the sender leaves a cycle empty
    int   stall_pct  = 0;    // chance that the receiver drops tready
    logic hold_phase = 1'b0; // ask the receiver for one long hold-off
    logic hold_taken = 1'b0;
    int   quiet      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    can_bit_timing_search_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cbts_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // Offer one word, with random empty cycles ahead of it, and hold it until
    // the block takes it. tvalid stays high into the next word when no gap
    // is drawn, so it is never lowered and raised within one step.
    task automatic send_word(input logic [CLK_W-1:0] clock_hz,
                             input logic [BAUD_W-1:0] baud_hz);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-CLK_W-BAUD_W){1'b0}}, baud_hz, clock_hz};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Pick a bit rate such that (quotient + 1) * rate still fits 32 bits, then
    // build a clock rate that divides down to the quotient, with a random
    // remainder so that truncation is exercised.
    task automatic send_quotient(input int unsigned quotient);
        int unsigned cap;
        int unsigned baud;
        cap = 32'hFFFF_FFFF / (quotient + 1);
        if (cap > 32'h000F_FFFF)
            cap = 32'h000F_FFFF;
        if ($urandom_range(3) == 0 && cap > 1000)
            cap = 1000;
        baud = $urandom_range(cap, 1);
        send_word(quotient * baud + $urandom_range(baud - 1), baud[BAUD_W-1:0]);
    endtask

    // Mostly well-formed requests that land on a real divider/quanta/segment
    // product (small dividers favoured to keep searches short), then
    // arbitrary quotients, then raw noise and zero bit rates.
    task automatic send_random();
        int unsigned pick;
        int unsigned d;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            d = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
            send_quotient((d + 1) * $urandom_range(32, 1) * $urandom_range(17, 3));
        end
        else if (pick < 85)
            send_quotient($urandom_range(9000, 1));
        else if (pick < 95)
            send_word($urandom, BAUD_W'($urandom_range(32'h000F_FFFF)));
        else
            send_word($urandom, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off when asked, counted here
    // so that the block backs up and stalls its input meanwhile.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_phase && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("can_bit_timing_search_top regression: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int idle_sel[4];
        int stall_sel[4];
        idle_sel  = '{0, 50, 0, 35};
        stall_sel = '{0, 0, 50, 35};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, back to back
        send_word(32'd0, 20'd0);                     // zero bit rate
        send_word(32'hFFFF_FFFF, 20'd0);             // zero bit rate, full clock
        send_word(32'd0, 20'd1);                     // quotient of zero: no match
        send_word(32'hFFFF_FFFF, 20'd1);             // huge quotient: no match
        send_word(32'hFFFF_FFFF, 20'hFFFFF);         // bit rate above its range
        send_word(32'h8000_0000, 20'h80000);         // single high bits
        send_word(32'h5555_5555, 20'hAAAAA);         // alternating bits
        send_word(32'd1500000, 20'd500000);          // smallest product, 3
        send_word(32'd870400000, 20'd100000);        // largest product, last divider
        send_word(32'd17000000, 20'd1000000);        // widest segments, sjw clipped
        send_word(32'd1000000, 20'd250000);          // four segments, seg1 zero
        send_word(32'd750000, 20'd125000);           // several matches: order decides
        send_word(32'd48000000, 20'd500000);         // everyday rate
        send_word(32'd48499999, 20'd500000);         // truncated quotient
        send_word(32'd16000000, 20'd125000);
        send_word(32'd190000, 20'd10000);            // prime above the segment range
        send_word(32'd2000000, 20'd1000000);         // below the smallest product
        send_word(32'd7680000, 20'd1000);

        // Back-pressure: hold the receiver off while fast words keep coming
        hold_phase <= 1'b1;
        repeat (6) send_word($urandom, '0);
        hold_phase <= 1'b0;

        // Random words over the idling mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = idle_sel[phase];
            stall_pct <= stall_sel[phase];
            repeat (RANDOM_WORDS / 4) send_random();
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block a little longer to show any stray result
        @(negedge clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("can_bit_timing_search_top regression: pass");
        else
            $display("can_bit_timing_search_top regression: fail");
        $finish;
    end

endmodule
